// ===== hdl/dep_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Shared constants, command and status codes and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int OUT_CNT_W = 11;
  localparam int STAT_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_MAX = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [VAL_W-1:0]  value;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dep_cell.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue cell
// Holds one value of a sorted chain and updates it from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_cell (
  input  wire logic                              clk,
  input  wire logic                              desc,
  input  wire dep_pkg::ctrl_t                    ctrl,
  input  wire logic                              in_use,
  input  wire logic signed [dep_pkg::VAL_W-1:0]  prev_val,
  input  wire logic                              prev_ahead,
  input  wire logic signed [dep_pkg::VAL_W-1:0]  next_val,
  output logic signed [dep_pkg::VAL_W-1:0]       val,
  output logic                                   ahead
);

  logic signed [dep_pkg::VAL_W-1:0] val_r;
  logic signed [dep_pkg::VAL_W-1:0] val_nxt;

  // The new value belongs ahead of this cell, or the cell is unused.
  assign ahead = !in_use ||
                 (desc ? (val_r < ctrl.value) : (ctrl.value < val_r));
  assign val   = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      dep_pkg::OP_INSERT: begin
        if (ahead) begin
          val_nxt = prev_ahead ? prev_val : ctrl.value;
        end
      end
      dep_pkg::OP_SHIFT: begin
        val_nxt = next_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/dep_chain.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue chain
// A row of cells kept sorted, ascending or descending, with its head exposed.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_chain (
  input  wire logic                              clk,
  input  wire logic                              desc,
  input  wire dep_pkg::ctrl_t                    ctrl,
  input  wire logic [dep_pkg::CNT_W-1:0]         count,
  output logic signed [dep_pkg::VAL_W-1:0]       head
);

  logic signed [dep_pkg::VAL_W-1:0] val [dep_pkg::CAPACITY];
  logic                             bef [dep_pkg::CAPACITY];

  for (genvar i = 0; i < dep_pkg::CAPACITY; i++) begin : g_cell
    logic signed [dep_pkg::VAL_W-1:0] prev_val;
    logic                             prev_ahead;
    logic signed [dep_pkg::VAL_W-1:0] next_val;
    logic                             in_use;

    assign in_use = dep_pkg::CNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign prev_val   = ctrl.value;
      assign prev_ahead = 1'b0;
    end else begin : g_mid
      assign prev_val   = val[i-1];
      assign prev_ahead = bef[i-1];
    end

    if (i == dep_pkg::CAPACITY - 1) begin : g_last
      assign next_val = val[i];
    end else begin : g_inner
      assign next_val = val[i+1];
    end

    dep_cell u_cell (
      .clk        (clk),
      .desc       (desc),
      .ctrl       (ctrl),
      .in_use     (in_use),
      .prev_val   (prev_val),
      .prev_ahead (prev_ahead),
      .next_val   (next_val),
      .val        (val[i]),
      .ahead      (bef[i])
    );
  end

  assign head = val[0];

endmodule

`default_nettype wire

// ===== hdl/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue
// The result strobe comes in the cycle after a request is accepted.
// One request is taken per cycle; busy stays low.
// Two sorted cell chains, one ascending and one descending, hold the values.
// Reset empties the queue; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [dep_pkg::CMD_W-1:0]            in_command,
  input  wire logic signed [dep_pkg::VAL_W-1:0]     in_value,
  output logic                                      out_valid,
  output logic signed [dep_pkg::VAL_W-1:0]          out_max_value,
  output logic signed [dep_pkg::VAL_W-1:0]          out_min_value,
  output logic [dep_pkg::OUT_CNT_W-1:0]             out_count,
  output logic [dep_pkg::STAT_W-1:0]                out_status
);

  logic                               accept;
  logic [dep_pkg::CNT_W-1:0]          count_r;
  logic [dep_pkg::CNT_W-1:0]          count_nxt;
  logic                               out_valid_r;
  logic [dep_pkg::STAT_W-1:0]         status_r;
  logic [dep_pkg::STAT_W-1:0]         status_nxt;
  dep_pkg::ctrl_t                     asc_ctrl;
  dep_pkg::ctrl_t                     desc_ctrl;
  logic signed [dep_pkg::VAL_W-1:0]   asc_head;
  logic signed [dep_pkg::VAL_W-1:0]   desc_head;
  logic [31:0]                        count_ext;
  logic                               empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    count_nxt       = count_r;
    status_nxt      = dep_pkg::ST_DONE;
    asc_ctrl.op     = dep_pkg::OP_HOLD;
    asc_ctrl.value  = in_value;
    desc_ctrl.op    = dep_pkg::OP_HOLD;
    desc_ctrl.value = in_value;
    if (accept) begin
      unique case (in_command)
        dep_pkg::CMD_INSERT: begin
          if (count_r >= dep_pkg::CNT_W'(dep_pkg::CAPACITY)) begin
            status_nxt = dep_pkg::ST_FULL;
          end else begin
            asc_ctrl.op  = dep_pkg::OP_INSERT;
            desc_ctrl.op = dep_pkg::OP_INSERT;
            count_nxt    = count_r + 1'b1;
          end
        end
        dep_pkg::CMD_DEL_MIN: begin
          if (count_r == '0) begin
            status_nxt = dep_pkg::ST_EMPTY;
          end else begin
            asc_ctrl.op = dep_pkg::OP_SHIFT;
            count_nxt   = count_r - 1'b1;
          end
        end
        dep_pkg::CMD_DEL_MAX: begin
          if (count_r == '0) begin
            status_nxt = dep_pkg::ST_EMPTY;
          end else begin
            desc_ctrl.op = dep_pkg::OP_SHIFT;
            count_nxt    = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = dep_pkg::ST_DONE;
        end
      endcase
    end
  end

  dep_chain u_asc (
    .clk   (clk),
    .desc  (1'b0),
    .ctrl  (asc_ctrl),
    .count (count_r),
    .head  (asc_head)
  );

  dep_chain u_desc (
    .clk   (clk),
    .desc  (1'b1),
    .ctrl  (desc_ctrl),
    .count (count_r),
    .head  (desc_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= dep_pkg::ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
      end
    end
  end

  assign empty         = count_r == '0;
  assign count_ext     = 32'(count_r);
  assign out_valid     = out_valid_r;
  assign out_max_value = empty ? '0 : desc_head;
  assign out_min_value = empty ? '0 : asc_head;
  assign out_count     = count_ext[dep_pkg::OUT_CNT_W-1:0];
  assign out_status    = status_r;

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("Accepted request produced no result.");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty |-> out_min_value <= out_max_value)
    else $error("Smallest value exceeds largest value.");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dep_pkg::ST_FULL |->
      count_r == dep_pkg::CNT_W'(dep_pkg::CAPACITY))
    else $error("Insert dropped while the queue was not full.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("Count changed without a request.");

endmodule

`default_nettype wire

// ===== dv/double_ended_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue checker
// Watches the request and result channels and keeps its own sorted copy of
// the stored values. Each accepted request yields one expected report, and
// each strobed result is compared field by field with the oldest one owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_priority_queue_checker
  import dep_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [CMD_W-1:0]          in_command,
  input  wire logic signed [VAL_W-1:0]   in_value,
  input  wire logic                      out_valid,
  input  wire logic signed [VAL_W-1:0]   out_max_value,
  input  wire logic signed [VAL_W-1:0]   out_min_value,
  input  wire logic [OUT_CNT_W-1:0]      out_count,
  input  wire logic [STAT_W-1:0]         out_status,
  output int                             fail_count,
  output int                             results_owed
);

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] min_value;
    logic [OUT_CNT_W-1:0]    count;
    logic [STAT_W-1:0]       status;
  } report_t;

  logic signed [VAL_W-1:0] sorted_values[$];
  report_t                 owed_reports[$];
  int                      mismatches = 0;

  function automatic report_t apply_request(input logic [CMD_W-1:0] cmd,
                                            input logic signed [VAL_W-1:0] val);
    report_t rep;
    int      pos;
    rep.status = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (sorted_values.size() >= CAPACITY) begin
          rep.status = ST_FULL;
        end else begin
          pos = sorted_values.size();
          while (pos > 0 && val < sorted_values[pos-1]) pos--;
          sorted_values.insert(pos, val);
        end
      end
      CMD_DEL_MIN, CMD_DEL_MAX: begin
        if (sorted_values.size() == 0) begin
          rep.status = ST_EMPTY;
        end else if (cmd == CMD_DEL_MIN) begin
          void'(sorted_values.pop_front());
        end else begin
          sorted_values.delete(sorted_values.size() - 1);
        end
      end
      default: begin
      end
    endcase
    if (sorted_values.size() == 0) begin
      rep.max_value = '0;
      rep.min_value = '0;
    end else begin
      rep.max_value = sorted_values[sorted_values.size()-1];
      rep.min_value = sorted_values[0];
    end
    rep.count = OUT_CNT_W'(sorted_values.size());
    return rep;
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      sorted_values.delete();
      owed_reports.delete();
    end else begin
      if (out_valid) begin
        if (owed_reports.size() == 0) begin
          $error("Result strobe with no request outstanding.");
          mismatches++;
        end else begin
          want = owed_reports.pop_front();
          if (out_max_value !== want.max_value) begin
            $error("out_max_value: expected %0d, got %0d", want.max_value, out_max_value);
            mismatches++;
          end
          if (out_min_value !== want.min_value) begin
            $error("out_min_value: expected %0d, got %0d", want.min_value, out_min_value);
            mismatches++;
          end
          if (out_count !== want.count) begin
            $error("out_count: expected %0d, got %0d", want.count, out_count);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        owed_reports = {owed_reports, apply_request(in_command, in_value)};
      end
    end
    results_owed <= owed_reports.size();
    fail_count   <= mismatches;
  end

endmodule

// ===== dv/double_ended_priority_queue_test.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue testbench
// Drives directed requests on the edge cases and then random phases that mix,
// fill the queue to capacity and drain it, with random sender gaps. A checker
// beside the block predicts every report and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_priority_queue_test;
  import dep_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_command = CMD_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_max_value;
  logic signed [VAL_W-1:0] out_min_value;
  logic [OUT_CNT_W-1:0]    out_count;
  logic [STAT_W-1:0]       out_status;
  int                      fail_count;
  int                      results_owed;
  int                      held = 0;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  double_ended_priority_queue dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_max_value (out_max_value),
    .out_min_value (out_min_value),
    .out_count     (out_count),
    .out_status    (out_status)
  );

  double_ended_priority_queue_checker queue_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_max_value (out_max_value),
    .out_min_value (out_min_value),
    .out_count     (out_count),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int insert_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return CMD_INSERT;
    if (roll >= 97) return CMD_UNUSED;
    return $urandom_range(0, 1) ? CMD_DEL_MIN : CMD_DEL_MAX;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                       input bit may_idle);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy);
    if (cmd == CMD_INSERT && held < CAPACITY) begin
      held++;
    end else if ((cmd == CMD_DEL_MIN || cmd == CMD_DEL_MAX) && held > 0) begin
      held--;
    end
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start      <= 1'b0;
      in_command <= CMD_W'($urandom);
      in_value   <= VAL_W'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    issue(CMD_DEL_MIN, '1, 1'b0);
    issue(CMD_DEL_MAX, '0, 1'b0);
    issue(CMD_UNUSED, '1, 1'b0);
    issue(CMD_INSERT, '0, 1'b0);
    issue(CMD_INSERT, VAL_MAX, 1'b0);
    issue(CMD_INSERT, VAL_MIN, 1'b1);
    issue(CMD_INSERT, -1, 1'b0);
    issue(CMD_INSERT, 1, 1'b0);
    issue(CMD_INSERT, VAL_MAX, 1'b0);
    issue(CMD_INSERT, '0, 1'b1);
    issue(CMD_UNUSED, VAL_MIN, 1'b0);
    issue(CMD_DEL_MAX, VAL_MAX, 1'b0);
    issue(CMD_DEL_MAX, '0, 1'b0);
    issue(CMD_DEL_MIN, '0, 1'b1);
    issue(CMD_DEL_MIN, '0, 1'b0);
    issue(CMD_DEL_MAX, '0, 1'b0);
    issue(CMD_DEL_MIN, '0, 1'b0);
    issue(CMD_DEL_MAX, '0, 1'b0);
    issue(CMD_DEL_MIN, '0, 1'b0);
    issue(CMD_UNUSED, '0, 1'b0);

    repeat (150) issue(pick_command(55), pick_value(), 1'b1);

    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);

    while (held < CAPACITY) issue(pick_command(95), pick_value(), 1'b1);
    repeat (6) issue(CMD_INSERT, pick_value(), 1'b1);
    repeat (600) issue(pick_command(20), pick_value(), 1'b1);
    repeat (150) issue(pick_command(45), pick_value(), 1'b0);

    start <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 200 && results_owed != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (results_owed != 0) begin
      $error("%0d expected results never arrived.", results_owed);
    end
    if (fail_count == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dep_pkg.sv
hdl/dep_cell.sv
hdl/dep_chain.sv
hdl/double_ended_priority_queue.sv
dv/double_ended_priority_queue_checker.sv
dv/double_ended_priority_queue_test.sv
